FILE: sv/sps_pkg.sv
package sps_pkg;

	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int MW = DW + 1;
	localparam int PW = 2 * MW;
	localparam int AW = PW + 2;
	localparam int RW = 2 * DW;
	localparam int TW = 31;
	localparam int FW = 32;
	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam int PAR_SHIFT = 40;
	localparam logic [TW-1:0] TOL_RESET = TW'(7);

	localparam logic signed [AW-1:0] CMAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [AW-1:0] CMIN = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] sax;
		logic signed [CW-1:0] say;
		logic signed [CW-1:0] sbx;
		logic signed [CW-1:0] sby;
		logic signed [CW-1:0] oax;
		logic signed [CW-1:0] oay;
		logic signed [CW-1:0] obx;
		logic signed [CW-1:0] oby;
		logic signed [DW-1:0] d1x;
		logic signed [DW-1:0] d1y;
		logic signed [DW-1:0] d2x;
		logic signed [DW-1:0] d2y;
		logic                 zero;
	} item_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_L1A, ST_L1B, ST_L2A, ST_L2B,
		ST_SQ1S, ST_SQ1W, ST_SQ2S, ST_SQ2W,
		ST_EREL, ST_EDOT1, ST_EDOT2, ST_ECHK, ST_EDIV,
		ST_EEND1, ST_EEND2, ST_EX1, ST_EX2, ST_ETOL,
		ST_CD1, ST_CD2, ST_CPAR, ST_CT1, ST_CT2, ST_CU1, ST_CU2,
		ST_CCHK, ST_CDIVT, ST_CDIVUS, ST_CDIVU,
		ST_CE1, ST_CE2, ST_CE3, ST_CE4, ST_COX, ST_COY,
		ST_CEMIT, ST_CEMIT2, ST_FIN
	} state_t;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [AW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > CMAX) begin
			r = CMAX[CW-1:0];
		end else if (v < CMIN) begin
			r = CMIN[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [AW-1:0] abs_acc(input logic signed [AW-1:0] v);
		return v[AW-1] ? -v : v;
	endfunction

endpackage

FILE: sv/segment_pair_split_points_top.sv
// Splits a pair of line segments against each other.
// Input: a beat of eight signed Q16.16 coordinates is taken at a clock edge where start is
// high and busy is low. Output: each split is shown for one cycle with result_valid high;
// the receiver cannot stall, so no back-pressure exists on the result side.
// Every pair yields one to six beats, the last marked by last_of_pair; a pair with no
// split yields one beat with no_split and last_of_pair set and all other fields zero.
// The weld tolerance is written on the cfg channel (cfg_ready is always high); the user
// must write it only while the block is idle, unchecked by the block; reset sets it to 7.
// A pair with a zero-length segment goes from the input register through the queue and
// the sequencer straight to its final beat; other pairs also pass one shared 34x34
// multiplier, two 33-step square roots and up to six 32-step restoring divisions in the
// back end.
// Throughput is one pair per back-end run; a two-entry queue and an input register let
// up to three pairs wait behind the one in the back end before busy rises.
// Reset clears the queue, the sequencer and the result strobe; no clearing pass is needed.
module segment_pair_split_points_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sps_pkg::TW-1:0]        cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [sps_pkg::CW-1:0] first_start_x,
	input  logic signed [sps_pkg::CW-1:0] first_start_y,
	input  logic signed [sps_pkg::CW-1:0] first_end_x,
	input  logic signed [sps_pkg::CW-1:0] first_end_y,
	input  logic signed [sps_pkg::CW-1:0] second_start_x,
	input  logic signed [sps_pkg::CW-1:0] second_start_y,
	input  logic signed [sps_pkg::CW-1:0] second_end_x,
	input  logic signed [sps_pkg::CW-1:0] second_end_y,
	output logic                          result_valid,
	output logic                          on_second,
	output logic [sps_pkg::FW-1:0]        split_param,
	output logic signed [sps_pkg::CW-1:0] split_x,
	output logic signed [sps_pkg::CW-1:0] split_y,
	output logic                          no_split,
	output logic                          last_of_pair
);

	logic [sps_pkg::TW-1:0] tol_q;
	logic                   push, pop, q_empty, q_full;
	sps_pkg::item_t         push_data, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= sps_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	sps_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_end_x(first_end_x), .first_end_y(first_end_y),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_end_x(second_end_x), .second_end_y(second_end_y),
		.q_full(q_full), .busy(busy), .push(push), .push_data(push_data)
	);

	sps_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(q_head), .empty(q_empty), .full(q_full)
	);

	sps_back u_back (
		.clk(clk), .arst_n(arst_n), .tol(tol_q), .q_empty(q_empty), .q_head(q_head),
		.pop(pop), .result_valid(result_valid), .on_second(on_second),
		.split_param(split_param), .split_x(split_x), .split_y(split_y),
		.no_split(no_split), .last_of_pair(last_of_pair)
	);

endmodule

FILE: sv/sps_frac.sv
module sps_frac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sps_pkg::PW-1:0]    num,
	input  logic [sps_pkg::PW-1:0]    den,
	output logic                      done,
	output logic [sps_pkg::FW-1:0]    quo
);

	logic [sps_pkg::PW-1:0] rem_q;
	logic [sps_pkg::PW-1:0] den_q;
	logic [sps_pkg::FW-1:0] quo_q;
	logic [5:0]             cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [sps_pkg::PW:0]   r2;
	logic                   ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(sps_pkg::FW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? sps_pkg::PW'(r2 - {1'b0, den_q}) : sps_pkg::PW'(r2);
			quo_q <= {quo_q[sps_pkg::FW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: sv/sps_isqrt.sv
module sps_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sps_pkg::RW-1:0]    rad,
	output logic                      done,
	output logic [sps_pkg::DW-1:0]    root
);

	logic [sps_pkg::RW-1:0] rad_q;
	logic [sps_pkg::DW:0]   rem_q;
	logic [sps_pkg::DW-1:0] root_q;
	logic [5:0]             cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [sps_pkg::DW+2:0] rem2;
	logic [sps_pkg::DW+2:0] trial;
	logic                   ge;

	assign rem2  = {rem_q, rad_q[sps_pkg::RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(sps_pkg::DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[sps_pkg::RW-3:0], 2'b00};
			rem_q  <= ge ? (sps_pkg::DW + 1)'(rem2 - trial) : (sps_pkg::DW + 1)'(rem2);
			root_q <= {root_q[sps_pkg::DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: sv/sps_front.sv
module sps_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [sps_pkg::CW-1:0] first_start_x,
	input  logic signed [sps_pkg::CW-1:0] first_start_y,
	input  logic signed [sps_pkg::CW-1:0] first_end_x,
	input  logic signed [sps_pkg::CW-1:0] first_end_y,
	input  logic signed [sps_pkg::CW-1:0] second_start_x,
	input  logic signed [sps_pkg::CW-1:0] second_start_y,
	input  logic signed [sps_pkg::CW-1:0] second_end_x,
	input  logic signed [sps_pkg::CW-1:0] second_end_y,
	input  logic                         q_full,
	output logic                         busy,
	output logic                         push,
	output sps_pkg::item_t               push_data
);

	logic           valid_s1;
	sps_pkg::item_t item_s1;
	sps_pkg::item_t item_d;
	logic           take;

	always_comb begin
		item_d.sax  = first_start_x;
		item_d.say  = first_start_y;
		item_d.sbx  = first_end_x;
		item_d.sby  = first_end_y;
		item_d.oax  = second_start_x;
		item_d.oay  = second_start_y;
		item_d.obx  = second_end_x;
		item_d.oby  = second_end_y;
		item_d.d1x  = $signed({first_end_x[sps_pkg::CW-1], first_end_x})
			- $signed({first_start_x[sps_pkg::CW-1], first_start_x});
		item_d.d1y  = $signed({first_end_y[sps_pkg::CW-1], first_end_y})
			- $signed({first_start_y[sps_pkg::CW-1], first_start_y});
		item_d.d2x  = $signed({second_end_x[sps_pkg::CW-1], second_end_x})
			- $signed({second_start_x[sps_pkg::CW-1], second_start_x});
		item_d.d2y  = $signed({second_end_y[sps_pkg::CW-1], second_end_y})
			- $signed({second_start_y[sps_pkg::CW-1], second_start_y});
		item_d.zero = ((item_d.d1x == '0) && (item_d.d1y == '0))
			|| ((item_d.d2x == '0) && (item_d.d2y == '0));
	end

	assign busy = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;
	assign take = start && !busy;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

FILE: sv/sps_queue.sv
module sps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sps_pkg::item_t push_data,
	input  logic           pop,
	output sps_pkg::item_t head,
	output logic           empty,
	output logic           full
);

	sps_pkg::item_t            mem_q [sps_pkg::QDEPTH];
	logic [sps_pkg::QPW-1:0]   wr_q;
	logic [sps_pkg::QPW-1:0]   rd_q;
	logic [sps_pkg::QCW-1:0]   cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == sps_pkg::QCW'(sps_pkg::QDEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + sps_pkg::QPW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + sps_pkg::QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + sps_pkg::QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - sps_pkg::QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sps_pkg::QCW'(sps_pkg::QDEPTH)) else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + sps_pkg::QCW'(1))
		else $error("queue count did not advance");
`endif

endmodule

FILE: sv/sps_back.sv
module sps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sps_pkg::TW-1:0]        tol,
	input  logic                          q_empty,
	input  sps_pkg::item_t                q_head,
	output logic                          pop,
	output logic                          result_valid,
	output logic                          on_second,
	output logic [sps_pkg::FW-1:0]        split_param,
	output logic signed [sps_pkg::CW-1:0] split_x,
	output logic signed [sps_pkg::CW-1:0] split_y,
	output logic                          no_split,
	output logic                          last_of_pair
);

	localparam logic [sps_pkg::MW-1:0] ONE_Q32 = sps_pkg::MW'(1) << sps_pkg::FW;
	localparam logic [sps_pkg::AW-1:0] HALF_Q32 = sps_pkg::AW'(1) << (sps_pkg::FW - 1);

	sps_pkg::state_t state_q, state_d;

	sps_pkg::item_t               it_q;
	logic signed [sps_pkg::AW-1:0] acc_q, den_q, tn_q, un_q;
	logic [sps_pkg::RW-1:0]       l1_q, l2_q;
	logic [sps_pkg::DW-1:0]       len1_q, len2_q;
	logic [1:0]                   idx_q;
	logic signed [sps_pkg::DW-1:0] relx_q, rely_q;
	logic [sps_pkg::FW-1:0]       tq_q, uq_q;
	logic                         ok_q;
	logic signed [sps_pkg::CW-1:0] px_q, py_q;
	logic                         pend_v_q, pend_on_q;
	logic [sps_pkg::FW-1:0]       pend_t_q;
	logic signed [sps_pkg::CW-1:0] pend_x_q, pend_y_q;
	logic                         out_v_q, out_on_q, out_ns_q, out_last_q;
	logic [sps_pkg::FW-1:0]       out_t_q;
	logic signed [sps_pkg::CW-1:0] out_x_q, out_y_q;

	logic signed [sps_pkg::MW-1:0] mul_a, mul_b;
	logic signed [sps_pkg::PW-1:0] prod;
	logic signed [sps_pkg::AW-1:0] prod_x, lim, dens, tns, uns, off, rnd;
	logic signed [sps_pkg::CW-1:0] epqx, epqy, epax, epay;
	logic signed [sps_pkg::DW-1:0] epdx, epdy, rx, ry;
	logic [sps_pkg::DW-1:0]       eplen;
	logic [sps_pkg::RW-1:0]       epl2;
	logic                         lim_ok, ep_pass, chk_pass, cr_pass, offneg;
	logic                         sq_start, sq_done, dv_start, dv_done;
	logic [sps_pkg::RW-1:0]       sq_rad;
	logic [sps_pkg::DW-1:0]       sq_root;
	logic [sps_pkg::PW-1:0]       dv_num, dv_den;
	logic [sps_pkg::FW-1:0]       dv_quo;
	logic                         fnd, fnd_on;
	logic [sps_pkg::FW-1:0]       fnd_t;
	logic signed [sps_pkg::CW-1:0] fnd_x, fnd_y;

	sps_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(sq_rad),
		.done(sq_done), .root(sq_root)
	);

	sps_frac u_frac (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_quo)
	);

	always_comb begin
		case (idx_q)
			2'd0: begin epqx = it_q.oax; epqy = it_q.oay; end
			2'd1: begin epqx = it_q.obx; epqy = it_q.oby; end
			2'd2: begin epqx = it_q.sax; epqy = it_q.say; end
			default: begin epqx = it_q.sbx; epqy = it_q.sby; end
		endcase
		epax  = idx_q[1] ? it_q.oax : it_q.sax;
		epay  = idx_q[1] ? it_q.oay : it_q.say;
		epdx  = idx_q[1] ? it_q.d2x : it_q.d1x;
		epdy  = idx_q[1] ? it_q.d2y : it_q.d1y;
		eplen = idx_q[1] ? len2_q : len1_q;
		epl2  = idx_q[1] ? l2_q : l1_q;
		rx = $signed({epqx[sps_pkg::CW-1], epqx}) - $signed({epax[sps_pkg::CW-1], epax});
		ry = $signed({epqy[sps_pkg::CW-1], epqy}) - $signed({epay[sps_pkg::CW-1], epay});
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sps_pkg::ST_L1A: begin
				mul_a = sps_pkg::MW'(it_q.d1x); mul_b = sps_pkg::MW'(it_q.d1x);
			end
			sps_pkg::ST_L1B: begin
				mul_a = sps_pkg::MW'(it_q.d1y); mul_b = sps_pkg::MW'(it_q.d1y);
			end
			sps_pkg::ST_L2A: begin
				mul_a = sps_pkg::MW'(it_q.d2x); mul_b = sps_pkg::MW'(it_q.d2x);
			end
			sps_pkg::ST_L2B: begin
				mul_a = sps_pkg::MW'(it_q.d2y); mul_b = sps_pkg::MW'(it_q.d2y);
			end
			sps_pkg::ST_EDOT1: begin
				mul_a = sps_pkg::MW'(relx_q); mul_b = sps_pkg::MW'(epdx);
			end
			sps_pkg::ST_EDOT2: begin
				mul_a = sps_pkg::MW'(rely_q); mul_b = sps_pkg::MW'(epdy);
			end
			sps_pkg::ST_EEND1: begin
				mul_a = $signed(sps_pkg::MW'(tq_q));
				mul_b = $signed(sps_pkg::MW'(eplen));
			end
			sps_pkg::ST_EEND2: begin
				mul_a = $signed(ONE_Q32 - sps_pkg::MW'(tq_q));
				mul_b = $signed(sps_pkg::MW'(eplen));
			end
			sps_pkg::ST_EX1: begin
				mul_a = sps_pkg::MW'(epdx); mul_b = sps_pkg::MW'(rely_q);
			end
			sps_pkg::ST_EX2: begin
				mul_a = sps_pkg::MW'(epdy); mul_b = sps_pkg::MW'(relx_q);
			end
			sps_pkg::ST_ETOL: begin
				mul_a = $signed(sps_pkg::MW'(tol));
				mul_b = $signed(sps_pkg::MW'(eplen));
			end
			sps_pkg::ST_CD1: begin
				mul_a = sps_pkg::MW'(it_q.d1x); mul_b = sps_pkg::MW'(it_q.d2y);
			end
			sps_pkg::ST_CD2: begin
				mul_a = sps_pkg::MW'(it_q.d1y); mul_b = sps_pkg::MW'(it_q.d2x);
			end
			sps_pkg::ST_CPAR: begin
				mul_a = $signed(sps_pkg::MW'(len1_q));
				mul_b = $signed(sps_pkg::MW'(len2_q));
			end
			sps_pkg::ST_CT1: begin
				mul_a = sps_pkg::MW'(relx_q); mul_b = sps_pkg::MW'(it_q.d2y);
			end
			sps_pkg::ST_CT2: begin
				mul_a = sps_pkg::MW'(rely_q); mul_b = sps_pkg::MW'(it_q.d2x);
			end
			sps_pkg::ST_CU1: begin
				mul_a = sps_pkg::MW'(relx_q); mul_b = sps_pkg::MW'(it_q.d1y);
			end
			sps_pkg::ST_CU2: begin
				mul_a = sps_pkg::MW'(rely_q); mul_b = sps_pkg::MW'(it_q.d1x);
			end
			sps_pkg::ST_CE1: begin
				mul_a = $signed(sps_pkg::MW'(tq_q));
				mul_b = $signed(sps_pkg::MW'(len1_q));
			end
			sps_pkg::ST_CE2: begin
				mul_a = $signed(ONE_Q32 - sps_pkg::MW'(tq_q));
				mul_b = $signed(sps_pkg::MW'(len1_q));
			end
			sps_pkg::ST_CE3: begin
				mul_a = $signed(sps_pkg::MW'(uq_q));
				mul_b = $signed(sps_pkg::MW'(len2_q));
			end
			sps_pkg::ST_CE4: begin
				mul_a = $signed(ONE_Q32 - sps_pkg::MW'(uq_q));
				mul_b = $signed(sps_pkg::MW'(len2_q));
			end
			sps_pkg::ST_COX: begin
				mul_a = $signed(sps_pkg::MW'(tq_q));
				mul_b = it_q.d1x[sps_pkg::DW-1] ? -sps_pkg::MW'(it_q.d1x)
					: sps_pkg::MW'(it_q.d1x);
			end
			sps_pkg::ST_COY: begin
				mul_a = $signed(sps_pkg::MW'(tq_q));
				mul_b = it_q.d1y[sps_pkg::DW-1] ? -sps_pkg::MW'(it_q.d1y)
					: sps_pkg::MW'(it_q.d1y);
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign prod_x = sps_pkg::AW'(prod);
	assign lim    = $signed(sps_pkg::AW'({tol, {sps_pkg::FW{1'b0}}}));
	assign lim_ok = lim < prod_x;
	assign dens   = den_q[sps_pkg::AW-1] ? -den_q : den_q;
	assign tns    = den_q[sps_pkg::AW-1] ? -tn_q : tn_q;
	assign uns    = den_q[sps_pkg::AW-1] ? -un_q : un_q;
	assign rnd    = prod_x + $signed(HALF_Q32);
	assign offneg = (state_q == sps_pkg::ST_COX) ? it_q.d1x[sps_pkg::DW-1]
		: it_q.d1y[sps_pkg::DW-1];
	assign off    = offneg ? -(rnd >>> sps_pkg::FW) : (rnd >>> sps_pkg::FW);

	assign chk_pass = !acc_q[sps_pkg::AW-1] && (acc_q != '0)
		&& (acc_q < $signed(sps_pkg::AW'(epl2)));
	assign ep_pass  = ok_q && !(prod_x < sps_pkg::abs_acc(acc_q));
	assign cr_pass  = !tns[sps_pkg::AW-1] && (tns != '0) && (tns < dens)
		&& !uns[sps_pkg::AW-1] && (uns != '0) && (uns < dens);

	assign sq_start = (state_q == sps_pkg::ST_SQ1S) || (state_q == sps_pkg::ST_SQ2S);
	assign sq_rad   = (state_q == sps_pkg::ST_SQ1S) ? l1_q : l2_q;
	assign dv_start = ((state_q == sps_pkg::ST_ECHK) && chk_pass)
		|| ((state_q == sps_pkg::ST_CCHK) && cr_pass)
		|| (state_q == sps_pkg::ST_CDIVUS);
	assign dv_num   = (state_q == sps_pkg::ST_ECHK) ? acc_q[sps_pkg::PW-1:0]
		: (state_q == sps_pkg::ST_CCHK) ? tns[sps_pkg::PW-1:0] : uns[sps_pkg::PW-1:0];
	assign dv_den   = (state_q == sps_pkg::ST_ECHK) ? sps_pkg::PW'(epl2)
		: dens[sps_pkg::PW-1:0];

	assign pop = (state_q == sps_pkg::ST_IDLE) && !q_empty;

	always_comb begin
		fnd    = 1'b0;
		fnd_on = 1'b0;
		fnd_t  = tq_q;
		fnd_x  = px_q;
		fnd_y  = py_q;
		case (state_q)
			sps_pkg::ST_ETOL: begin
				fnd    = ep_pass;
				fnd_on = idx_q[1];
				fnd_x  = epqx;
				fnd_y  = epqy;
			end
			sps_pkg::ST_CEMIT: fnd = 1'b1;
			sps_pkg::ST_CEMIT2: begin
				fnd    = 1'b1;
				fnd_on = 1'b1;
				fnd_t  = uq_q;
			end
			default: fnd = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sps_pkg::ST_IDLE: begin
				if (!q_empty) state_d = q_head.zero ? sps_pkg::ST_FIN : sps_pkg::ST_L1A;
			end
			sps_pkg::ST_L1A:    state_d = sps_pkg::ST_L1B;
			sps_pkg::ST_L1B:    state_d = sps_pkg::ST_L2A;
			sps_pkg::ST_L2A:    state_d = sps_pkg::ST_L2B;
			sps_pkg::ST_L2B:    state_d = sps_pkg::ST_SQ1S;
			sps_pkg::ST_SQ1S:   state_d = sps_pkg::ST_SQ1W;
			sps_pkg::ST_SQ1W:   if (sq_done) state_d = sps_pkg::ST_SQ2S;
			sps_pkg::ST_SQ2S:   state_d = sps_pkg::ST_SQ2W;
			sps_pkg::ST_SQ2W:   if (sq_done) state_d = sps_pkg::ST_EREL;
			sps_pkg::ST_EREL:   state_d = sps_pkg::ST_EDOT1;
			sps_pkg::ST_EDOT1:  state_d = sps_pkg::ST_EDOT2;
			sps_pkg::ST_EDOT2:  state_d = sps_pkg::ST_ECHK;
			sps_pkg::ST_ECHK: begin
				if (chk_pass) begin
					state_d = sps_pkg::ST_EDIV;
				end else begin
					state_d = (idx_q == 2'd3) ? sps_pkg::ST_CD1 : sps_pkg::ST_EREL;
				end
			end
			sps_pkg::ST_EDIV:   if (dv_done) state_d = sps_pkg::ST_EEND1;
			sps_pkg::ST_EEND1:  state_d = sps_pkg::ST_EEND2;
			sps_pkg::ST_EEND2:  state_d = sps_pkg::ST_EX1;
			sps_pkg::ST_EX1:    state_d = sps_pkg::ST_EX2;
			sps_pkg::ST_EX2:    state_d = sps_pkg::ST_ETOL;
			sps_pkg::ST_ETOL: begin
				state_d = (idx_q == 2'd3) ? sps_pkg::ST_CD1 : sps_pkg::ST_EREL;
			end
			sps_pkg::ST_CD1:    state_d = sps_pkg::ST_CD2;
			sps_pkg::ST_CD2:    state_d = sps_pkg::ST_CPAR;
			sps_pkg::ST_CPAR: begin
				if ((prod_x >>> sps_pkg::PAR_SHIFT) < sps_pkg::abs_acc(den_q)) begin
					state_d = sps_pkg::ST_CT1;
				end else begin
					state_d = sps_pkg::ST_FIN;
				end
			end
			sps_pkg::ST_CT1:    state_d = sps_pkg::ST_CT2;
			sps_pkg::ST_CT2:    state_d = sps_pkg::ST_CU1;
			sps_pkg::ST_CU1:    state_d = sps_pkg::ST_CU2;
			sps_pkg::ST_CU2:    state_d = sps_pkg::ST_CCHK;
			sps_pkg::ST_CCHK:   state_d = cr_pass ? sps_pkg::ST_CDIVT : sps_pkg::ST_FIN;
			sps_pkg::ST_CDIVT:  if (dv_done) state_d = sps_pkg::ST_CDIVUS;
			sps_pkg::ST_CDIVUS: state_d = sps_pkg::ST_CDIVU;
			sps_pkg::ST_CDIVU:  if (dv_done) state_d = sps_pkg::ST_CE1;
			sps_pkg::ST_CE1:    state_d = sps_pkg::ST_CE2;
			sps_pkg::ST_CE2:    state_d = sps_pkg::ST_CE3;
			sps_pkg::ST_CE3:    state_d = sps_pkg::ST_CE4;
			sps_pkg::ST_CE4: begin
				state_d = (ok_q && lim_ok) ? sps_pkg::ST_COX : sps_pkg::ST_FIN;
			end
			sps_pkg::ST_COX:    state_d = sps_pkg::ST_COY;
			sps_pkg::ST_COY:    state_d = sps_pkg::ST_CEMIT;
			sps_pkg::ST_CEMIT:  state_d = sps_pkg::ST_CEMIT2;
			sps_pkg::ST_CEMIT2: state_d = sps_pkg::ST_FIN;
			sps_pkg::ST_FIN:    state_d = sps_pkg::ST_IDLE;
			default:            state_d = sps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sps_pkg::ST_IDLE:  begin it_q <= q_head; idx_q <= 2'd0; end
			sps_pkg::ST_L1A:   acc_q <= prod_x;
			sps_pkg::ST_L1B:   l1_q <= sps_pkg::RW'(acc_q + prod_x);
			sps_pkg::ST_L2A:   acc_q <= prod_x;
			sps_pkg::ST_L2B:   l2_q <= sps_pkg::RW'(acc_q + prod_x);
			sps_pkg::ST_SQ1W:  if (sq_done) len1_q <= sq_root;
			sps_pkg::ST_SQ2W:  if (sq_done) len2_q <= sq_root;
			sps_pkg::ST_EREL:  begin relx_q <= rx; rely_q <= ry; end
			sps_pkg::ST_EDOT1: acc_q <= prod_x;
			sps_pkg::ST_EDOT2: acc_q <= acc_q + prod_x;
			sps_pkg::ST_ECHK:  if (!chk_pass) idx_q <= idx_q + 2'd1;
			sps_pkg::ST_EDIV:  if (dv_done) tq_q <= dv_quo;
			sps_pkg::ST_EEND1: ok_q <= lim_ok;
			sps_pkg::ST_EEND2: ok_q <= ok_q && lim_ok;
			sps_pkg::ST_EX1:   acc_q <= prod_x;
			sps_pkg::ST_EX2:   acc_q <= acc_q - prod_x;
			sps_pkg::ST_ETOL:  idx_q <= idx_q + 2'd1;
			sps_pkg::ST_CD1:   acc_q <= prod_x;
			sps_pkg::ST_CD2:   den_q <= acc_q - prod_x;
			sps_pkg::ST_CPAR: begin
				relx_q <= $signed({it_q.oax[sps_pkg::CW-1], it_q.oax})
					- $signed({it_q.sax[sps_pkg::CW-1], it_q.sax});
				rely_q <= $signed({it_q.oay[sps_pkg::CW-1], it_q.oay})
					- $signed({it_q.say[sps_pkg::CW-1], it_q.say});
			end
			sps_pkg::ST_CT1:   acc_q <= prod_x;
			sps_pkg::ST_CT2:   tn_q <= acc_q - prod_x;
			sps_pkg::ST_CU1:   acc_q <= prod_x;
			sps_pkg::ST_CU2:   un_q <= acc_q - prod_x;
			sps_pkg::ST_CDIVT: if (dv_done) tq_q <= dv_quo;
			sps_pkg::ST_CDIVU: if (dv_done) uq_q <= dv_quo;
			sps_pkg::ST_CE1:   ok_q <= lim_ok;
			sps_pkg::ST_CE2:   ok_q <= ok_q && lim_ok;
			sps_pkg::ST_CE3:   ok_q <= ok_q && lim_ok;
			sps_pkg::ST_COX: begin
				px_q <= sps_pkg::sat_coord(sps_pkg::AW'(it_q.sax) + off);
			end
			sps_pkg::ST_COY: begin
				py_q <= sps_pkg::sat_coord(sps_pkg::AW'(it_q.say) + off);
			end
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			if (fnd) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (state_q == sps_pkg::ST_FIN) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fnd) begin
			out_on_q   <= pend_on_q;
			out_t_q    <= pend_t_q;
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_ns_q   <= 1'b0;
			out_last_q <= 1'b0;
			pend_on_q  <= fnd_on;
			pend_t_q   <= fnd_t;
			pend_x_q   <= fnd_x;
			pend_y_q   <= fnd_y;
		end else if (state_q == sps_pkg::ST_FIN) begin
			out_on_q   <= pend_v_q && pend_on_q;
			out_t_q    <= pend_v_q ? pend_t_q : '0;
			out_x_q    <= pend_v_q ? pend_x_q : '0;
			out_y_q    <= pend_v_q ? pend_y_q : '0;
			out_ns_q   <= !pend_v_q;
			out_last_q <= 1'b1;
		end
	end

	assign result_valid = out_v_q;
	assign on_second    = out_on_q;
	assign split_param  = out_t_q;
	assign split_x      = out_x_q;
	assign split_y      = out_y_q;
	assign no_split     = out_ns_q;
	assign last_of_pair = out_last_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == sps_pkg::ST_IDLE) else $error("item taken while working");
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sps_pkg::ST_FIN |=> result_valid && last_of_pair)
		else $error("missing final beat");
	a_nosplit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && no_split) |-> last_of_pair) else $error("empty beat not final");
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sps_pkg::ST_FIN |=> !pend_v_q) else $error("pending split left over");
`endif

endmodule

FILE: tb/segment_pair_split_points_top_tb.sv
typedef logic signed [127:0] wide_t;

typedef struct packed {
	logic        on_second;
	logic [31:0] split_param;
	logic [31:0] split_x;
	logic [31:0] split_y;
	logic        no_split;
	logic        last_of_pair;
} split_beat_t;

class split_scoreboard;
	split_beat_t pending[int];
	int          head_idx;
	int          tail_idx;
	logic [30:0] tol;
	int          mismatches;
	int          pairs;
	int          beats;
	int          splits;

	function new();
		tol = sps_pkg::TOL_RESET;
		head_idx = 0;
		tail_idx = 0;
		mismatches = 0;
		pairs = 0;
		beats = 0;
		splits = 0;
	endfunction

	function void add_expected(split_beat_t b);
		pending[tail_idx] = b;
		tail_idx++;
	endfunction

	function wide_t isqrt(wide_t n);
		wide_t r;
		wide_t c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (wide_t'(1) << b);
			if (c * c <= n) begin
				r = c;
			end
		end
		return r;
	endfunction

	function wide_t frac32(wide_t num, wide_t den);
		wide_t q;
		wide_t r;
		q = 0;
		r = num;
		for (int i = 0; i < 32; i++) begin
			r = r + r;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function bit ends_clear(wide_t tq, wide_t len);
		wide_t lim;
		lim = wide_t'(tol) << 32;
		return (lim < tq * len) && (lim < ((wide_t'(1) << 32) - tq) * len);
	endfunction

	function wide_t mag(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function bit endpoint_on(wide_t qx, wide_t qy, wide_t ax, wide_t ay, wide_t dx,
			wide_t dy, wide_t len, wide_t l2, output wide_t tq);
		wide_t rx;
		wide_t ry;
		wide_t dt;
		rx = qx - ax;
		ry = qy - ay;
		dt = rx * dx + ry * dy;
		tq = 0;
		if (dt <= 0 || dt >= l2) begin
			return 0;
		end
		tq = frac32(dt, l2);
		if (!ends_clear(tq, len)) begin
			return 0;
		end
		if (wide_t'(tol) * len < mag(dx * ry - dy * rx)) begin
			return 0;
		end
		return 1;
	endfunction

	function wide_t offset(wide_t tq, wide_t d);
		wide_t v;
		v = (tq * mag(d) + (wide_t'(1) << 31)) >>> 32;
		return (d < 0) ? -v : v;
	endfunction

	function logic [31:0] sat(wide_t v);
		if (v > 64'sh7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function void push_split(logic on, wide_t tq, wide_t px, wide_t py);
		split_beat_t b;
		b.on_second = on;
		b.split_param = tq[31:0];
		b.split_x = sat(px);
		b.split_y = sat(py);
		b.no_split = 0;
		b.last_of_pair = 0;
		add_expected(b);
	endfunction

	function void note_pair(logic signed [31:0] c[8]);
		wide_t sax, say, sbx, sby, oax, oay, obx, oby;
		wide_t d1x, d1y, d2x, d2y, l1sq, l2sq, len1, len2, tq, uq;
		wide_t den, tn, un, rx, ry;
		split_beat_t b;
		int found;
		sax = c[0]; say = c[1]; sbx = c[2]; sby = c[3];
		oax = c[4]; oay = c[5]; obx = c[6]; oby = c[7];
		d1x = sbx - sax; d1y = sby - say;
		d2x = obx - oax; d2y = oby - oay;
		found = 0;
		pairs++;
		if (!((d1x == 0 && d1y == 0) || (d2x == 0 && d2y == 0))) begin
			l1sq = d1x * d1x + d1y * d1y;
			l2sq = d2x * d2x + d2y * d2y;
			len1 = isqrt(l1sq);
			len2 = isqrt(l2sq);
			if (endpoint_on(oax, oay, sax, say, d1x, d1y, len1, l1sq, tq)) begin
				push_split(0, tq, oax, oay);
				found++;
			end
			if (endpoint_on(obx, oby, sax, say, d1x, d1y, len1, l1sq, tq)) begin
				push_split(0, tq, obx, oby);
				found++;
			end
			if (endpoint_on(sax, say, oax, oay, d2x, d2y, len2, l2sq, tq)) begin
				push_split(1, tq, sax, say);
				found++;
			end
			if (endpoint_on(sbx, sby, oax, oay, d2x, d2y, len2, l2sq, tq)) begin
				push_split(1, tq, sbx, sby);
				found++;
			end
			den = d1x * d2y - d1y * d2x;
			if (((len1 * len2) >>> 40) < mag(den)) begin
				rx = oax - sax;
				ry = oay - say;
				tn = rx * d2y - ry * d2x;
				un = rx * d1y - ry * d1x;
				if (den < 0) begin
					den = -den;
					tn = -tn;
					un = -un;
				end
				if (tn > 0 && tn < den && un > 0 && un < den) begin
					tq = frac32(tn, den);
					uq = frac32(un, den);
					if (ends_clear(tq, len1) && ends_clear(uq, len2)) begin
						push_split(0, tq, sax + offset(tq, d1x), say + offset(tq, d1y));
						push_split(1, uq, sax + offset(tq, d1x), say + offset(tq, d1y));
						found += 2;
					end
				end
			end
		end
		if (found == 0) begin
			b = '{0, 0, 0, 0, 1, 1};
			add_expected(b);
		end else begin
			pending[tail_idx - 1].last_of_pair = 1;
		end
	endfunction

	function void check_beat(split_beat_t got);
		split_beat_t want;
		beats++;
		if (!got.no_split) begin
			splits++;
		end
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Unexpected result beat: on=%0d t=%h x=%h y=%h none=%0d last=%0d",
					got.on_second, got.split_param, got.split_x, got.split_y,
					got.no_split, got.last_of_pair);
			end
			return;
		end
		want = pending[head_idx];
		pending.delete(head_idx);
		head_idx++;
		if (got != want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Mismatch expected on=%0d t=%h x=%h y=%h none=%0d last=%0d",
					want.on_second, want.split_param, want.split_x, want.split_y,
					want.no_split, want.last_of_pair);
				$display("         actual   on=%0d t=%h x=%h y=%h none=%0d last=%0d",
					got.on_second, got.split_param, got.split_x, got.split_y,
					got.no_split, got.last_of_pair);
			end
		end
	endfunction
endclass

module segment_pair_split_points_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [sps_pkg::TW-1:0] cfg_data = '0;
	logic start = 0;
	logic busy;
	logic signed [31:0] coord[8];
	logic result_valid;
	logic on_second;
	logic [31:0] split_param;
	logic signed [31:0] split_x;
	logic signed [31:0] split_y;
	logic no_split;
	logic last_of_pair;

	split_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;

	initial begin
		for (int i = 0; i < 8; i++) begin
			coord[i] = '0;
		end
	end

	always #4 clk = ~clk;

	segment_pair_split_points_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.first_start_x(coord[0]), .first_start_y(coord[1]),
		.first_end_x(coord[2]), .first_end_y(coord[3]),
		.second_start_x(coord[4]), .second_start_y(coord[5]),
		.second_end_x(coord[6]), .second_end_y(coord[7]),
		.result_valid(result_valid), .on_second(on_second), .split_param(split_param),
		.split_x(split_x), .split_y(split_y), .no_split(no_split),
		.last_of_pair(last_of_pair)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && result_valid) begin
			sb.check_beat('{on_second, split_param, split_x, split_y, no_split,
				last_of_pair});
		end
	end

	task automatic send_pair(input logic signed [31:0] c[8]);
		for (int i = 0; i < 8; i++) begin
			coord[i] <= c[i];
		end
		start <= 1;
		do begin
			@(posedge clk);
		end while (busy);
		sb.note_pair(c);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic set_tolerance(input logic [30:0] value);
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (400) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.tol = value;
		cfg_valid <= 0;
	endtask

	function automatic int near(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_shaped();
		logic signed [31:0] c[8];
		int kind;
		int k;
		int span;
		span = ($urandom_range(0, 3) == 0) ? 1 << 28 : 1 << 20;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 8; i++) begin
			c[i] = near(span);
		end
		if (kind <= 1) begin
			for (int i = 0; i < 8; i++) begin
				c[i] = $urandom;
			end
		end else if (kind <= 3) begin
			k = $urandom_range(1, 7);
			c[2] = c[0] + 8 * near(1 << 16);
			c[3] = c[1] + 8 * near(1 << 16);
			c[4 + 2 * $urandom_range(0, 1)] = c[0] + (c[2] - c[0]) / 8 * k;
			c[5 + 2 * (c[4] == c[0] + (c[2] - c[0]) / 8 * k ? 0 : 1)] =
				c[1] + (c[3] - c[1]) / 8 * k;
		end else if (kind == 4) begin
			k = $urandom_range(1, 7);
			c[6] = c[4] + 8 * near(1 << 16);
			c[7] = c[5] + 8 * near(1 << 16);
			c[0] = c[4] + (c[6] - c[4]) / 8 * k;
			c[1] = c[5] + (c[7] - c[5]) / 8 * k;
		end else if (kind == 5) begin
			c[2] = c[0];
			c[3] = c[1];
		end
		send_pair(c);
	endtask

	initial begin
		logic signed [31:0] d[8];
		logic signed [31:0] mx;
		logic signed [31:0] mn;
		mx = 32'sh7FFF_FFFF;
		mn = 32'sh8000_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		d = '{100, 100, 100, 100, 0, 0, 5000, 5000};
		send_pair(d);
		d = '{0, 0, 5000, 5000, 300, 300, 300, 300};
		send_pair(d);
		d = '{-65536, 0, 65536, 0, 0, -65536, 0, 65536};
		send_pair(d);
		d = '{0, 0, 65536, 0, 0, 4096, 65536, 4096};
		send_pair(d);
		d = '{0, 0, 65536, 0, 16384, 0, 16384, 9000};
		send_pair(d);
		d = '{0, 0, 65536, 0, 16384, 9000, 40000, 0};
		send_pair(d);
		d = '{20000, 0, 20000, 8000, 0, 0, 65536, 0};
		send_pair(d);
		d = '{20000, 8000, 20000, 0, 0, 0, 65536, 0};
		send_pair(d);
		d = '{0, 0, 65536, 65536, 16384, 16384, 131072, 131072};
		send_pair(d);
		d = '{mx, mx, mx, mx, mx, mx, mx, mx};
		send_pair(d);
		d = '{mn, mn, mn, mn, mn, mn, mn, mn};
		send_pair(d);
		d = '{mn, mn, mx, mx, mn, mx, mx, mn};
		send_pair(d);
		d = '{mn, 0, mx, 0, 0, mn, 0, mx};
		send_pair(d);
		d = '{0, 0, 65536, 3, 0, 1, 65536, 2};
		send_pair(d);
		d = '{0, 0, 65536, 0, 3, 2, 30000, 5};
		send_pair(d);
		d = '{-1, -1, 1, 1, -1, 1, 1, -1};
		send_pair(d);

		set_tolerance(0);
		send_pair(d);
		d = '{0, 0, 65536, 0, 16384, 0, 16384, 9000};
		send_pair(d);

		idle_pct = 28;
		set_tolerance(31'h7FFF_FFFF);
		repeat (10) send_shaped();
		set_tolerance(31'(7));
		repeat (50) send_shaped();

		idle_pct = 48;
		set_tolerance(31'($urandom_range(0, 2000)));
		repeat (50) send_shaped();

		idle_pct = 0;
		set_tolerance(31'(65536));
		repeat (25) send_shaped();
		set_tolerance(31'(0));
		repeat (17) send_shaped();

		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (400) @(posedge clk);
		$display("Ran %0d segment pairs over six tolerance settings and three idle patterns.",
			sb.pairs);
		$display("Checked %0d result beats, %0d of them splits; %0d mismatches.",
			sb.beats, sb.splits, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
